@@ rtl/hrp_pkg.sv @@
// Package for the hue-rotated palette generator: fixed-point constants,
// register indexes, control types and small helpers. No dependencies.
package hrp_pkg;

  localparam int unsigned CategoryCount = 7;
  localparam int unsigned CatW          = 4;   // holds categories 0..15
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [14:0] HueHalf  = 15'd11520;
  localparam logic [11:0] HueSixth = 12'd3840;
  localparam logic [8:0]  Q8One    = 9'd256;
  // 15 * Recip15 = 2^20 - 1, so (y * Recip15) >> 20 is y/15 or one below it.
  localparam logic [16:0] Recip15  = 17'd69905;

  localparam logic [8:0]  BonusSatReset    = 9'd184;
  localparam logic [8:0]  BonusValReset    = 9'd243;
  localparam logic [8:0]  DrawSatReset     = 9'd205;
  localparam logic [8:0]  DrawValReset     = 9'd184;
  localparam logic [14:0] DangerHueReset   = 15'd384;
  localparam logic [8:0]  BlendFracReset   = 9'd115;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBonusSat  = 3'd0,
    CfgBonusVal  = 3'd1,
    CfgDrawSat   = 3'd2,
    CfgDrawVal   = 3'd3,
    CfgDangerHue = 3'd4,
    CfgBlendFrac = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HueIdle,
    HueDivide,
    HueDone
  } hue_state_e;

  typedef struct packed {
    logic [CatW-1:0] cat;
    logic            drw;
    logic            last;
  } meta_t;

  function automatic logic [8:0] sat_q8(input logic [8:0] val);
    sat_q8 = (val > Q8One) ? Q8One : val;
  endfunction

endpackage

@@ rtl/hue_rotated_palette_generator.sv @@
// Top level of the hue-rotated palette generator: accent hue divider,
// run sequencer and an eight-stage HSV to RGB pipeline. Uses hrp_pkg.
//
//  channel   direction  transfer                     payload
//  s_axis    in         tvalid & tready              accent color
//  m_axis    out        tvalid & tready              one palette color
//  cfg       in         cfg_valid_i & cfg_ready_o    register index and data
//
// An accent color is accepted, then its hue is found by a bit-serial divider,
// which is skipped when all three channels are equal. The sequencer then
// issues 2*CATEGORY_COUNT colors, one per cycle unless m_axis stalls, into
// the pipeline. The divider takes the next accent while the previous run is
// still issued.
// Reset clears the control state and the registers, not the datapath. A stall
// at m_axis freezes every stage and the sequencer.
module hue_rotated_palette_generator #(
  parameter int unsigned CATEGORY_COUNT = hrp_pkg::CategoryCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] accent_red, [15:8] accent_green, [23:16] accent_blue
  input  logic [23:0]                  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [2:0] category, [10:3] out_red, [18:11] out_green, [26:19] out_blue
  output logic [31:0]                  m_axis_tdata_o,
  // [0] is_drawback
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hrp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam logic [hrp_pkg::CatW-1:0] LastCat = hrp_pkg::CatW'(CATEGORY_COUNT - 1);

  // ---------------- configuration ----------------
  logic [8:0]  bonus_sat_q, bonus_val_q, draw_sat_q, draw_val_q, blend_q;
  logic [14:0] danger_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bonus_sat_q <= hrp_pkg::BonusSatReset;
      bonus_val_q <= hrp_pkg::BonusValReset;
      draw_sat_q  <= hrp_pkg::DrawSatReset;
      draw_val_q  <= hrp_pkg::DrawValReset;
      danger_q    <= hrp_pkg::DangerHueReset;
      blend_q     <= hrp_pkg::BlendFracReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hrp_pkg::CfgBonusSat:  bonus_sat_q <= cfg_data_i[8:0];
        hrp_pkg::CfgBonusVal:  bonus_val_q <= cfg_data_i[8:0];
        hrp_pkg::CfgDrawSat:   draw_sat_q  <= cfg_data_i[8:0];
        hrp_pkg::CfgDrawVal:   draw_val_q  <= cfg_data_i[8:0];
        hrp_pkg::CfgDangerHue: danger_q    <= cfg_data_i[14:0];
        hrp_pkg::CfgBlendFrac: blend_q     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [14:0] danger_red;
  logic [8:0]  blend_sat;
  assign danger_red = (danger_q >= hrp_pkg::HueFull) ? danger_q - hrp_pkg::HueFull : danger_q;
  assign blend_sat  = hrp_pkg::sat_q8(blend_q);

  // ---------------- accent hue divider ----------------
  hrp_pkg::hue_state_e state_q, state_d;
  logic [7:0]  rem_q;
  logic [11:0] low_q;
  logic [7:0]  dvs_q;
  logic [14:0] base_q;
  logic        neg_q;
  logic [3:0]  cnt_q;

  logic        emit_busy_q;
  logic [hrp_pkg::CatW-1:0] cat_q;
  logic        drw_q;
  logic [14:0] held_hue_q;
  logic        en;
  logic        issue;

  logic [7:0]  in_r, in_g, in_b, mx, mn, delta, num_abs;
  logic [14:0] in_base;
  logic        in_neg;
  logic [19:0] dividend;
  logic [8:0]  trial;
  logic        trial_ge;
  logic [15:0] hue_sum;
  logic [14:0] hue_res;
  logic        s_fire, handoff;

  assign in_r = s_axis_tdata_i[7:0];
  assign in_g = s_axis_tdata_i[15:8];
  assign in_b = s_axis_tdata_i[23:16];

  always_comb begin
    mx = in_r;
    mn = in_r;
    if (in_g > mx) mx = in_g;
    if (in_b > mx) mx = in_b;
    if (in_g < mn) mn = in_g;
    if (in_b < mn) mn = in_b;
    delta = mx - mn;
    // Ties go to red first, then green.
    if (mx == in_r) begin
      in_base = 15'd0;
      in_neg  = in_b > in_g;
      num_abs = in_neg ? in_b - in_g : in_g - in_b;
    end else if (mx == in_g) begin
      in_base = 15'd7680;
      in_neg  = in_r > in_b;
      num_abs = in_neg ? in_r - in_b : in_b - in_r;
    end else begin
      in_base = 15'd15360;
      in_neg  = in_g > in_r;
      num_abs = in_neg ? in_g - in_r : in_r - in_g;
    end
    // A negative arc rounds up: add delta-1 before the floor division.
    dividend = 20'(num_abs) * 20'(hrp_pkg::HueSixth)
             + (in_neg ? 20'(delta - 8'd1) : 20'd0);
  end

  assign trial    = {rem_q, low_q[11]};
  assign trial_ge = trial >= {1'b0, dvs_q};

  always_comb begin
    hue_sum = neg_q ? 16'(base_q) + 16'(hrp_pkg::HueFull) - 16'(low_q)
                    : 16'(base_q) + 16'(low_q);
    hue_res = (hue_sum >= 16'(hrp_pkg::HueFull)) ? 15'(hue_sum - 16'(hrp_pkg::HueFull))
                                                  : hue_sum[14:0];
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    handoff         = 1'b0;
    case (state_q)
      hrp_pkg::HueIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = (delta == 8'd0) ? hrp_pkg::HueDone : hrp_pkg::HueDivide;
      end
      hrp_pkg::HueDivide: begin
        if (cnt_q == 4'd11) state_d = hrp_pkg::HueDone;
      end
      hrp_pkg::HueDone: begin
        // The next run may start in the cycle that issues the last color.
        if (!emit_busy_q || (issue && drw_q && (cat_q == LastCat))) begin
          handoff = 1'b1;
          state_d = hrp_pkg::HueIdle;
        end
      end
      default: state_d = hrp_pkg::HueIdle;
    endcase
  end

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hrp_pkg::HueIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cnt_q <= 4'd0;
      dvs_q <= delta;
      if (delta == 8'd0) begin
        rem_q  <= 8'd0;
        low_q  <= 12'd0;
        base_q <= 15'd0;
        neg_q  <= 1'b0;
      end else begin
        rem_q  <= dividend[19:12];
        low_q  <= dividend[11:0];
        base_q <= in_base;
        neg_q  <= in_neg;
      end
    end else if (state_q == hrp_pkg::HueDivide) begin
      rem_q <= trial_ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
      low_q <= {low_q[10:0], trial_ge};
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // ---------------- run sequencer ----------------
  logic [14:0] step_w [16];

  for (genvar i = 0; i < 16; i++) begin : g_step
    localparam int unsigned StepVal =
        (i < CATEGORY_COUNT) ? (i * 23040) / CATEGORY_COUNT : 0;
    assign step_w[i] = 15'(StepVal);
  end

  assign issue = emit_busy_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      cat_q       <= '0;
      drw_q       <= 1'b0;
      held_hue_q  <= '0;
    end else if (handoff) begin
      emit_busy_q <= 1'b1;
      cat_q       <= '0;
      drw_q       <= 1'b0;
      held_hue_q  <= hue_res;
    end else if (issue) begin
      if (cat_q == LastCat) begin
        cat_q <= '0;
        drw_q <= 1'b1;
        if (drw_q) emit_busy_q <= 1'b0;
      end else begin
        cat_q <= cat_q + 1'b1;
      end
    end
  end

  // ---------------- color pipeline ----------------
  logic out_valid_q;
  assign en = !out_valid_q || m_axis_tready_i;

  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  hrp_pkg::meta_t m1_q, m2_q, m3_q, m4_q, m5_q, m6_q, m7_q, mo_q;

  // Stage 1: stepped hue.
  logic [15:0] step_sum;
  logic [14:0] hue1_q;
  assign step_sum = 16'(held_hue_q) + 16'(step_w[cat_q]);

  // Stage 2: shortest arc toward the danger hue, times the blend fraction.
  logic signed [16:0] arc_x, arc_d;
  logic signed [24:0] arc_prod_q;
  logic [14:0] hue2_q;
  always_comb begin
    arc_x = $signed({2'b00, danger_red}) - $signed({2'b00, hue1_q});
    if (arc_x >= $signed({2'b00, hrp_pkg::HueHalf}))
      arc_d = arc_x - $signed({2'b00, hrp_pkg::HueFull});
    else if (arc_x < -$signed({2'b00, hrp_pkg::HueHalf}))
      arc_d = arc_x + $signed({2'b00, hrp_pkg::HueFull});
    else
      arc_d = arc_x;
  end

  // Stage 3: the hue, blended for drawback colors, and the saturation/value of this set.
  logic signed [16:0] arc_shift;
  logic signed [17:0] blend_sum, blend_wrap;
  logic [14:0] hue3_q;
  logic [8:0]  sat3_q, val3_q;
  always_comb begin
    arc_shift = 17'(arc_prod_q >>> 8);   // floor, also for a negative arc
    blend_sum = $signed({3'b000, hue2_q}) + 18'(arc_shift);
    if (blend_sum < 0)
      blend_wrap = blend_sum + $signed({3'b000, hrp_pkg::HueFull});
    else if (blend_sum >= $signed({3'b000, hrp_pkg::HueFull}))
      blend_wrap = blend_sum - $signed({3'b000, hrp_pkg::HueFull});
    else
      blend_wrap = blend_sum;
  end

  // Stage 4: chroma, sector and ramp factor.
  logic [2:0]  sector;
  logic [14:0] sector_base;
  logic [11:0] frac_h;
  logic [16:0] c4_q;
  logic [11:0] factor4_q;
  logic [2:0]  sector4_q;
  logic [8:0]  val4_q;
  always_comb begin
    if      (hue3_q >= 15'd19200) begin sector = 3'd5; sector_base = 15'd19200; end
    else if (hue3_q >= 15'd15360) begin sector = 3'd4; sector_base = 15'd15360; end
    else if (hue3_q >= 15'd11520) begin sector = 3'd3; sector_base = 15'd11520; end
    else if (hue3_q >= 15'd7680)  begin sector = 3'd2; sector_base = 15'd7680;  end
    else if (hue3_q >= 15'd3840)  begin sector = 3'd1; sector_base = 15'd3840;  end
    else                          begin sector = 3'd0; sector_base = 15'd0;     end
    frac_h = 12'(hue3_q - sector_base);
  end

  // Stage 5: chroma times ramp, and the offset m.
  logic [27:0] p5_q;
  logic [16:0] m_off5_q, c5_q;
  logic [2:0]  sector5_q;

  // Stage 6: division by 3840 as a shift and a reciprocal multiply.
  logic [36:0] recip_prod;
  logic [19:0] y6_q;
  logic [15:0] q6_q;
  logic [16:0] m_off6_q, c6_q;
  logic [2:0]  sector6_q;
  assign recip_prod = 37'(p5_q[27:8]) * 37'(hrp_pkg::Recip15);

  // Stage 7: correct the quotient, place channels, add m and clamp.
  logic [19:0] x_rem;
  logic [16:0] x_val, ch_r, ch_g, ch_b;
  logic [17:0] sum_r, sum_g, sum_b;
  logic [16:0] q7_r_q, q7_g_q, q7_b_q;
  always_comb begin
    x_rem = y6_q - 20'(q6_q) * 20'd15;
    x_val = 17'(q6_q) + ((x_rem >= 20'd15) ? 17'd1 : 17'd0);
    ch_r  = '0;
    ch_g  = '0;
    ch_b  = '0;
    case (sector6_q)
      3'd0:    begin ch_r = c6_q;  ch_g = x_val; end
      3'd1:    begin ch_r = x_val; ch_g = c6_q;  end
      3'd2:    begin ch_g = c6_q;  ch_b = x_val; end
      3'd3:    begin ch_g = x_val; ch_b = c6_q;  end
      3'd4:    begin ch_r = x_val; ch_b = c6_q;  end
      default: begin ch_r = c6_q;  ch_b = x_val; end
    endcase
    sum_r = 18'(ch_r) + 18'(m_off6_q);
    sum_g = 18'(ch_g) + 18'(m_off6_q);
    sum_b = 18'(ch_b) + 18'(m_off6_q);
  end

  function automatic logic [16:0] clamp_q16(input logic [17:0] val);
    clamp_q16 = (val > 18'd65536) ? 17'd65536 : val[16:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [16:0] q16);
    logic [24:0] prod;
    prod    = 25'(q16) * 25'd255;
    to_byte = prod[23:16];
  endfunction

  logic [7:0] out_r_q, out_g_q, out_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= emit_busy_q;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q.cat  <= cat_q;
      m1_q.drw  <= drw_q;
      m1_q.last <= drw_q && (cat_q == LastCat);
      hue1_q    <= (step_sum >= 16'(hrp_pkg::HueFull))
                   ? 15'(step_sum - 16'(hrp_pkg::HueFull)) : step_sum[14:0];

      m2_q       <= m1_q;
      hue2_q     <= hue1_q;
      arc_prod_q <= 25'(arc_d) * $signed({16'd0, blend_sat});

      m3_q   <= m2_q;
      hue3_q <= m2_q.drw ? blend_wrap[14:0] : hue2_q;
      sat3_q <= hrp_pkg::sat_q8(m2_q.drw ? draw_sat_q : bonus_sat_q);
      val3_q <= hrp_pkg::sat_q8(m2_q.drw ? draw_val_q : bonus_val_q);

      m4_q      <= m3_q;
      c4_q      <= 17'(sat3_q) * 17'(val3_q);
      factor4_q <= sector[0] ? hrp_pkg::HueSixth - frac_h : frac_h;
      sector4_q <= sector;
      val4_q    <= val3_q;

      m5_q      <= m4_q;
      p5_q      <= 28'(c4_q) * 28'(factor4_q);
      m_off5_q  <= {val4_q, 8'd0} - c4_q;
      c5_q      <= c4_q;
      sector5_q <= sector4_q;

      m6_q      <= m5_q;
      y6_q      <= p5_q[27:8];
      q6_q      <= recip_prod[35:20];
      m_off6_q  <= m_off5_q;
      c6_q      <= c5_q;
      sector6_q <= sector5_q;

      m7_q   <= m6_q;
      q7_r_q <= clamp_q16(sum_r);
      q7_g_q <= clamp_q16(sum_g);
      q7_b_q <= clamp_q16(sum_b);

      mo_q    <= m7_q;
      out_r_q <= to_byte(q7_r_q);
      out_g_q <= to_byte(q7_g_q);
      out_b_q <= to_byte(q7_b_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_b_q, out_g_q, out_r_q, 3'(mo_q.cat)};
  assign m_axis_tuser_o  = mo_q.drw;
  assign m_axis_tlast_o  = mo_q.last;

  // ---------------- assertions ----------------
  a_last_is_drawback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("last color of a run is not a drawback color");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("divider took a second accent while busy");

  a_cat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_busy_q |-> cat_q <= LastCat)
    else $error("category counter out of range");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hrp_pkg::HueDone && !emit_busy_q |=> emit_busy_q && cat_q == '0 && !drw_q)
    else $error("run did not start after hue was ready");

endmodule
